// ===== hdl/gcs_pkg.sv =====
// gcs_pkg: shared types and codes for the grid cursor cell store
// operation kinds, status codes, direction decode, controller states and
// the command/status structs between controller and datapath
`default_nettype none

package gcs_pkg;

  localparam int KIND_W    = 2;
  localparam int DIR_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int IO_WORD_W = 32;
  localparam int CFG_W     = 5;
  localparam int SIDE_RST  = 16;
  localparam int IN_DATA_W = 40;  // direction + element_value, padded to bytes

  typedef enum logic [KIND_W-1:0] {
    KIND_MOVE   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_CELL  = 2'd1,
    STAT_OCCUPIED = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_UPLEFT    = 3'd0,
    DIR_UP        = 3'd1,
    DIR_UPRIGHT   = 3'd2,
    DIR_LEFT      = 3'd3,
    DIR_RIGHT     = 3'd4,
    DIR_DOWNLEFT  = 3'd5,
    DIR_DOWN      = 3'd6,
    DIR_DOWNRIGHT = 3'd7
  } dir_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // take the input word and read the cursor cell
    logic exec;  // apply the operation and load the output register
  } gcs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } gcs_stat_t;

  // step flags per direction: {up, down, left, right}
  function automatic logic [3:0] dir_steps(input dir_t d);
    logic [3:0] s;
    unique case (d)
      DIR_UPLEFT:    s = 4'b1010;
      DIR_UP:        s = 4'b1000;
      DIR_UPRIGHT:   s = 4'b1001;
      DIR_LEFT:      s = 4'b0010;
      DIR_RIGHT:     s = 4'b0001;
      DIR_DOWNLEFT:  s = 4'b0110;
      DIR_DOWN:      s = 4'b0100;
      DIR_DOWNRIGHT: s = 4'b0101;
      default:       s = 4'b0000;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gcs_ctrl.sv =====
// gcs_ctrl: controller state machine for the grid cursor cell store
// sequences accept and execute; uses gcs_pkg
`default_nettype none

module gcs_ctrl
  import gcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire gcs_stat_t stat,
  output gcs_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // wait here while the previous result still sits unread
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gcs_dp.sv =====
// gcs_dp: datapath of the grid cursor cell store
// cursor, grid size, occupancy row memory with row valid flags, word memory,
// output register; uses gcs_pkg
`default_nettype none

module gcs_dp
  import gcs_pkg::*;
#(
  parameter int MAX_SIDE  = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_W-1:0]     cfg_wr_data,
  input  wire logic [KIND_W-1:0]    in_kind,
  input  wire logic [DIR_W-1:0]     in_dir,
  input  wire logic [IO_WORD_W-1:0] in_word,
  input  wire gcs_cmd_t             cmd,
  output gcs_stat_t                 stat,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [STATUS_W-1:0]       out_status,
  output logic [IO_WORD_W-1:0]      out_word
);

  localparam int RW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int SIDE0 = (SIDE_RST <= MAX_SIDE) ? SIDE_RST : MAX_SIDE;

  logic [SW-1:0]       side_r, side_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [RW-1:0]       col_r, col_nxt;
  logic [MAX_SIDE-1:0] row_valid_r, row_valid_nxt;
  logic                out_valid_r;
  status_t             out_status_r, status_nxt;
  logic [IO_WORD_W-1:0] out_word_r, out_word_nxt;

  kind_t               kind_r;
  dir_t                dir_r;
  logic [WORD_BITS-1:0] word_r;

  logic [MAX_SIDE-1:0]  occ_mem [MAX_SIDE];
  logic [WORD_BITS-1:0] word_mem [CELLS];
  logic [MAX_SIDE-1:0]  occ_q;
  logic [WORD_BITS-1:0] word_q;

  logic [AW-1:0]        addr;
  logic [63:0]          in_wide;
  logic [63:0]          rd_wide;
  logic [MAX_SIDE-1:0]  row_bits;
  logic [MAX_SIDE-1:0]  col_onehot;
  logic                 occupied;
  logic                 wr_cell;
  logic                 do_clear;
  logic [3:0]           steps;
  logic [SW-1:0]        row_p1, col_p1;
  logic                 move_ok;

  assign addr       = AW'(row_r) * AW'(MAX_SIDE) + AW'(col_r);
  assign in_wide    = 64'(in_word);
  assign rd_wide    = 64'(word_q);
  // a row not written since the last clear, grid size write or reset reads as empty
  assign row_bits   = row_valid_r[row_r] ? occ_q : '0;
  assign col_onehot = MAX_SIDE'(1) << col_r;
  assign occupied   = row_bits[col_r];
  assign steps      = dir_steps(dir_r);
  assign row_p1     = SW'(row_r) + SW'(1);
  assign col_p1     = SW'(col_r) + SW'(1);
  assign stat.out_free = !out_valid_r || out_tready;

  always_comb begin
    move_ok = 1'b1;
    if (steps[3] && row_r == '0) move_ok = 1'b0;
    if (steps[2] && !(row_p1 < side_r)) move_ok = 1'b0;
    if (steps[1] && col_r == '0) move_ok = 1'b0;
    if (steps[0] && !(col_p1 < side_r)) move_ok = 1'b0;
  end

  always_comb begin
    status_nxt   = STAT_OK;
    out_word_nxt = '0;
    row_nxt      = row_r;
    col_nxt      = col_r;
    wr_cell      = 1'b0;
    do_clear     = 1'b0;
    unique case (kind_r)
      KIND_MOVE: begin
        if (!move_ok) begin
          status_nxt = STAT_NO_CELL;
        end else begin
          if (steps[3]) row_nxt = row_r - RW'(1);
          if (steps[2]) row_nxt = row_r + RW'(1);
          if (steps[1]) col_nxt = col_r - RW'(1);
          if (steps[0]) col_nxt = col_r + RW'(1);
        end
      end
      KIND_INSERT: begin
        if (occupied) status_nxt = STAT_OCCUPIED;
        else          wr_cell    = (word_r != '0);
      end
      KIND_READ: begin
        if (!occupied) status_nxt   = STAT_EMPTY;
        else           out_word_nxt = rd_wide[IO_WORD_W-1:0];
      end
      KIND_CLEAR: begin
        do_clear = 1'b1;
        row_nxt  = '0;
        col_nxt  = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    side_nxt      = side_r;
    row_valid_nxt = row_valid_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        side_nxt = SW'(1);
      end else if (int'(cfg_wr_data) > MAX_SIDE) begin
        side_nxt = SW'(MAX_SIDE);
      end else begin
        side_nxt = SW'(cfg_wr_data);
      end
      row_valid_nxt = '0;
    end else if (cmd.exec) begin
      if (do_clear) row_valid_nxt = '0;
      else if (wr_cell) row_valid_nxt[row_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r       <= SW'(SIDE0);
      row_r        <= '0;
      col_r        <= '0;
      row_valid_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      side_r      <= side_nxt;
      row_valid_r <= row_valid_nxt;
      if (cfg_wr_en) begin
        row_r <= '0;
        col_r <= '0;
      end else if (cmd.exec) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (cmd.exec)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind_t'(in_kind);
      dir_r  <= dir_t'(in_dir);
      word_r <= in_wide[WORD_BITS-1:0];
    end
    if (cmd.exec) begin
      out_status_r <= status_nxt;
      out_word_r   <= out_word_nxt;
    end
  end

  // occupancy rows: read-modify-write of one row per insert
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_cell) occ_mem[row_r] <= row_bits | col_onehot;
    if (cmd.load) occ_q <= occ_mem[row_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_cell) word_mem[addr] <= word_r;
    if (cmd.load) word_q <= word_mem[addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire

// ===== hdl/grid_cursor_cell_store.sv =====
// grid_cursor_cell_store: square grid of word cells with a movable cursor
// an input is registered together with a read of the cursor cell, then executed and its result
// loaded into the output register; a new input is taken only after the previous one has executed
// an input is accepted while the previous result still waits in the output register
// reset (synchronous, rst_n low): grid side 16, cursor at row 0 column 0, all cells
// empty at once through per-row valid flags; no clearing pass
`default_nettype none

module grid_cursor_cell_store
  import gcs_pkg::*;
#(
  parameter int MAX_SIDE  = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_W-1:0]     cfg_wr_data,   // grid_side
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,      // [2:0] direction, [34:3] element_value
  input  wire logic [KIND_W-1:0]    in_tuser,      // [1:0] kind
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [IO_WORD_W-1:0]      out_tdata,     // [31:0] element_out
  output logic [STATUS_W-1:0]       out_tuser      // [1:0] status
);

  gcs_cmd_t  cmd;
  gcs_stat_t stat;

  gcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gcs_dp #(
    .MAX_SIDE  (MAX_SIDE),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_kind     (in_tuser),
    .in_dir      (in_tdata[DIR_W-1:0]),
    .in_word     (in_tdata[DIR_W+IO_WORD_W-1:DIR_W]),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (out_tuser),
    .out_word    (out_tdata)
  );

endmodule

`default_nettype wire
